// ----- hw/rtl/ipdfhp_pkg.sv -----
package ipdfhp_pkg;

    // Largest payload a header may announce; payload_len is 11 bits wide.
    localparam int MAX_PAYLOAD = 1024;
    localparam int LEN_CAP     = (MAX_PAYLOAD > 2047) ? 2047 : MAX_PAYLOAD;

    localparam int TDATA_W = 80;
    localparam int PREFIX_LEN = 5;

    // Result event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_HEADER = 2'd1;
    localparam logic [1:0] EV_DATA   = 2'd2;
    localparam logic [1:0] EV_ERROR  = 2'd3;

    // Parse phases
    localparam logic [3:0] PH_HUNT       = 4'd0;
    localparam logic [3:0] PH_ID_FIRST   = 4'd1;
    localparam logic [3:0] PH_ID_MORE    = 4'd2;
    localparam logic [3:0] PH_LEN_FIRST  = 4'd3;
    localparam logic [3:0] PH_LEN_MORE   = 4'd4;
    localparam logic [3:0] PH_QUOTE      = 4'd5;
    localparam logic [3:0] PH_OCT_FIRST  = 4'd6;
    localparam logic [3:0] PH_OCT_MORE   = 4'd7;
    localparam logic [3:0] PH_COMMA      = 4'd8;
    localparam logic [3:0] PH_PORT_FIRST = 4'd9;
    localparam logic [3:0] PH_PORT_MORE  = 4'd10;
    localparam logic [3:0] PH_PAYLOAD    = 4'd11;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  conn_id;
        logic [10:0] payload_len;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [7:0]  data_byte;
        logic        last_byte;
    } result_t;

    // Characters of the "+IPD," prefix by position
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = CH_PLUS;
            3'd1:    ch = 8'h49;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h44;
            3'd4:    ch = CH_COMMA;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- hw/rtl/ipdfhp_parser.sv -----
module ipdfhp_parser
    import ipdfhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output result_t    res
);

    localparam logic [14:0] LenLimit = 15'(LEN_CAP);

    logic [3:0]  phase_reg,  phase_next;
    logic [2:0]  prefix_reg, prefix_next;
    logic [7:0]  id_reg,     id_next;
    logic [10:0] len_reg,    len_next;
    logic [31:0] ip_reg,     ip_next;
    logic [7:0]  oct_reg,    oct_next;
    logic [1:0]  octidx_reg, octidx_next;
    logic [15:0] port_reg,   port_next;
    logic [10:0] left_reg,   left_next;

    logic        is_digit;
    logic        is_plus;
    logic [3:0]  digit;
    logic [11:0] id_sum;
    logic [11:0] oct_sum;
    logic [14:0] len_sum;
    logic [19:0] port_sum;
    logic [10:0] left_dec;
    logic        err;

    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_plus  = (rx_byte == CH_PLUS);
    assign digit    = rx_byte[3:0];

    // acc * 10 + digit as two shifts and adds
    assign id_sum   = ({4'b0, id_reg} << 3) + ({4'b0, id_reg} << 1) + {8'b0, digit};
    assign oct_sum  = ({4'b0, oct_reg} << 3) + ({4'b0, oct_reg} << 1) + {8'b0, digit};
    assign len_sum  = ({4'b0, len_reg} << 3) + ({4'b0, len_reg} << 1) + {11'b0, digit};
    assign port_sum = ({4'b0, port_reg} << 3) + ({4'b0, port_reg} << 1)
                    + {16'b0, digit};
    assign left_dec = left_reg - 11'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        prefix_next = prefix_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        ip_next     = ip_reg;
        oct_next    = oct_reg;
        octidx_next = octidx_reg;
        port_next   = port_reg;
        left_next   = left_reg;
        res         = '0;
        err         = 1'b0;

        unique case (phase_reg)
            PH_ID_FIRST, PH_ID_MORE:
            begin
                if (is_digit)
                begin
                    phase_next = PH_ID_MORE;
                    if (id_sum > 12'd255)
                        err = 1'b1;
                    else
                        id_next = id_sum[7:0];
                end
                else if (rx_byte == CH_COMMA && phase_reg == PH_ID_MORE)
                    phase_next = PH_LEN_FIRST;
                else
                    err = 1'b1;
            end
            PH_LEN_FIRST, PH_LEN_MORE:
            begin
                if (is_digit)
                begin
                    phase_next = PH_LEN_MORE;
                    if (len_sum > LenLimit)
                        err = 1'b1;
                    else
                        len_next = len_sum[10:0];
                end
                else if (rx_byte == CH_COMMA && phase_reg == PH_LEN_MORE)
                    phase_next = PH_QUOTE;
                else
                    err = 1'b1;
            end
            PH_QUOTE:
            begin
                if (rx_byte == CH_QUOTE)
                    phase_next = PH_OCT_FIRST;
                else
                    err = 1'b1;
            end
            PH_OCT_FIRST, PH_OCT_MORE:
            begin
                if (is_digit)
                begin
                    phase_next = PH_OCT_MORE;
                    if (oct_sum > 12'd255)
                        err = 1'b1;
                    else
                        oct_next = oct_sum[7:0];
                end
                else if (phase_reg == PH_OCT_MORE && rx_byte == CH_DOT
                         && octidx_reg != 2'd3)
                begin
                    ip_next     = {ip_reg[23:0], oct_reg};
                    oct_next    = '0;
                    octidx_next = octidx_reg + 2'd1;
                    phase_next  = PH_OCT_FIRST;
                end
                else if (phase_reg == PH_OCT_MORE && rx_byte == CH_QUOTE
                         && octidx_reg == 2'd3)
                begin
                    ip_next     = {ip_reg[23:0], oct_reg};
                    oct_next    = '0;
                    octidx_next = '0;
                    phase_next  = PH_COMMA;
                end
                else
                    err = 1'b1;
            end
            PH_COMMA:
            begin
                if (rx_byte == CH_COMMA)
                    phase_next = PH_PORT_FIRST;
                else
                    err = 1'b1;
            end
            PH_PORT_FIRST, PH_PORT_MORE:
            begin
                if (is_digit)
                begin
                    phase_next = PH_PORT_MORE;
                    if (port_sum > 20'd65535)
                        err = 1'b1;
                    else
                        port_next = port_sum[15:0];
                end
                else if (rx_byte == CH_COLON && phase_reg == PH_PORT_MORE)
                begin
                    res.event_res   = EV_HEADER;
                    res.conn_id     = id_reg;
                    res.payload_len = len_reg;
                    res.peer_ip     = ip_reg;
                    res.peer_port   = port_reg;
                    left_next       = len_reg;
                    if (len_reg == '0)
                    begin
                        phase_next  = PH_HUNT;
                        prefix_next = '0;
                    end
                    else
                        phase_next = PH_PAYLOAD;
                end
                else
                    err = 1'b1;
            end
            PH_PAYLOAD:
            begin
                res.event_res   = EV_DATA;
                res.conn_id     = id_reg;
                res.payload_len = len_reg;
                res.peer_ip     = ip_reg;
                res.peer_port   = port_reg;
                res.data_byte   = rx_byte;
                left_next       = left_dec;
                if (left_dec == '0)
                begin
                    res.last_byte = 1'b1;
                    phase_next    = PH_HUNT;
                    prefix_next   = '0;
                end
            end
            default:
            begin
                // hunt for the prefix; unused phase codes land here too
                phase_next = PH_HUNT;
                if (prefix_reg < 3'(PREFIX_LEN) && rx_byte == prefix_char(prefix_reg))
                begin
                    if (prefix_reg == 3'(PREFIX_LEN - 1))
                    begin
                        prefix_next = '0;
                        id_next     = '0;
                        len_next    = '0;
                        ip_next     = '0;
                        oct_next    = '0;
                        octidx_next = '0;
                        port_next   = '0;
                        left_next   = '0;
                        phase_next  = PH_ID_FIRST;
                    end
                    else
                        prefix_next = prefix_reg + 3'd1;
                end
                else
                    prefix_next = is_plus ? 3'd1 : 3'd0;
            end
        endcase

        // drop the frame; a '+' here already starts the next prefix
        if (err)
        begin
            res           = '0;
            res.event_res = EV_ERROR;
            phase_next    = PH_HUNT;
            prefix_next   = is_plus ? 3'd1 : 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            prefix_reg <= '0;
            id_reg     <= '0;
            len_reg    <= '0;
            ip_reg     <= '0;
            oct_reg    <= '0;
            octidx_reg <= '0;
            port_reg   <= '0;
            left_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            prefix_reg <= prefix_next;
            id_reg     <= id_next;
            len_reg    <= len_next;
            ip_reg     <= ip_next;
            oct_reg    <= oct_next;
            octidx_reg <= octidx_next;
            port_reg   <= port_next;
            left_reg   <= left_next;
        end
    end

endmodule

// ----- hw/rtl/ipd_frame_header_parser.sv -----
// Streaming parser for "+IPD,<id>,<len>,"<a.b.c.d>",<port>:<payload>" receive
// frames. Every received byte taken on the slave side yields exactly one
// result transaction on the master side: nothing, header complete, payload
// byte (tlast on the final one) or format error. Bytes pass through an input
// register, combinational parse logic and a result register, so a result shows
// on m_tvalid once it is held in the result register; throughput is one byte
// per cycle while downstream accepts, and both registers keep moving while
// downstream stalls until each holds an item.
module ipd_frame_header_parser
    import ipdfhp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // conn_id[7:0], payload_len[18:8], peer_ip[50:19], peer_port[66:51],
    // data_byte[74:67], zero fill [79:75]
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,   // event_res
    output logic               m_tlast    // last_byte
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    result_t    parse_res;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ipdfhp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .res     (parse_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (advance)
            out_res_reg <= parse_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.event_res;
    assign m_tlast  = out_res_reg.last_byte;
    assign m_tdata  = {5'b0, out_res_reg.data_byte, out_res_reg.peer_port,
                       out_res_reg.peer_ip, out_res_reg.payload_len,
                       out_res_reg.conn_id};

endmodule

// ----- hw/rtl/ipdfhp_checker.sv -----
module ipdfhp_checker
    import ipdfhp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [1:0]         m_tuser,
    input logic               m_tlast
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // with the result register empty, the input side must never stall
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output idle");

    a_last_on_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == EV_DATA)
        else $error("tlast on non-payload result");

    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == EV_NONE || m_tuser == EV_ERROR)
            |-> m_tdata == '0 && !m_tlast)
        else $error("fields not cleared on empty or error result");

endmodule

bind ipd_frame_header_parser ipdfhp_checker u_ipdfhp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
